// ----- src/bdeq_pkg.sv -----
// shared constants and types of the button debouncer with event queue
`default_nettype none
package bdeq_pkg;

  localparam int BUTTONS_DEF     = 9;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int HOLD_SAMPLES    = 2;
  localparam int HOLD_W          = $clog2(HOLD_SAMPLES + 1);

  localparam int RAW_W  = 9;
  localparam int TIME_W = 32;
  localparam int TICK_W = 8;
  localparam int BTN_W  = 4;
  localparam int TYPE_W = 2;
  localparam int CFG_W  = 8;

  localparam logic [TICK_W-1:0] TICK_RESET       = TICK_W'(5);
  localparam logic              ACTIVE_LOW_RESET = 1'b1;

  // register indexes of the configuration port
  localparam logic CFG_TICK       = 1'b0;
  localparam logic CFG_ACTIVE_LOW = 1'b1;

  // event type codes
  localparam logic [TYPE_W-1:0] EVT_PRESS   = 2'd0;
  localparam logic [TYPE_W-1:0] EVT_RELEASE = 2'd1;
  localparam logic [TYPE_W-1:0] EVT_CLICK   = 2'd2;

  // what one lane found on an accepted sample
  typedef struct packed {
    logic press;
    logic rel;
  } lane_req_t;

  // one write into the event ring
  typedef struct packed {
    logic              valid;
    logic [BTN_W-1:0]  button;
    logic [TYPE_W-1:0] etype;
  } enq_t;

endpackage
`default_nettype wire

// ----- src/bdeq_lane.sv -----
// one debounce lane: per-button hold counter and stable state
`default_nettype none
module bdeq_lane (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                update,
  input  wire logic                level,
  output bdeq_pkg::lane_req_t      req
);

  logic                          stable_r, stable_nxt;
  logic                          prev_r, prev_nxt;
  logic [bdeq_pkg::HOLD_W-1:0]   hold_r, hold_nxt;

  always_comb begin
    stable_nxt = stable_r;
    prev_nxt   = prev_r;
    hold_nxt   = hold_r;
    req        = '0;
    if (level != prev_r) begin
      hold_nxt = '0;
      prev_nxt = level;
    end else if (hold_r < bdeq_pkg::HOLD_W'(bdeq_pkg::HOLD_SAMPLES)) begin
      hold_nxt = hold_r + 1'b1;
      if (hold_nxt == bdeq_pkg::HOLD_W'(bdeq_pkg::HOLD_SAMPLES) && level != stable_r) begin
        stable_nxt = level;
        req.press  = level;
        req.rel    = ~level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      prev_r   <= 1'b0;
      hold_r   <= '0;
    end else if (update) begin
      stable_r <= stable_nxt;
      prev_r   <= prev_nxt;
      hold_r   <= hold_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/bdeq_merge.sv -----
// merging stage: walks the lane requests in button order, at most one ring write a cycle
`default_nettype none
module bdeq_merge #(
  parameter int BUTTONS = bdeq_pkg::BUTTONS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [BUTTONS-1:0] press_vec,
  input  wire logic [BUTTONS-1:0] rel_vec,
  output logic                    busy,
  output bdeq_pkg::enq_t          enq
);

  localparam int SW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  logic [BUTTONS-1:0] press_pend_r;
  logic [BUTTONS-1:0] rel_pend_r;
  logic [SW-1:0]      scan_r;
  logic               phase_r;
  logic               active_r;
  logic               cur_press, cur_rel, last;

  assign cur_press = press_pend_r[scan_r];
  assign cur_rel   = rel_pend_r[scan_r];
  assign last      = (scan_r == SW'(BUTTONS - 1));
  assign busy      = active_r;

  always_comb begin
    enq        = '0;
    enq.valid  = active_r & (cur_press | cur_rel);
    enq.button = bdeq_pkg::BTN_W'(scan_r);
    if (cur_press) begin
      enq.etype = bdeq_pkg::EVT_PRESS;
    end else if (phase_r) begin
      enq.etype = bdeq_pkg::EVT_CLICK;
    end else begin
      enq.etype = bdeq_pkg::EVT_RELEASE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      scan_r   <= '0;
      phase_r  <= 1'b0;
    end else if (start) begin
      active_r <= |(press_vec | rel_vec);
      scan_r   <= '0;
      phase_r  <= 1'b0;
    end else if (active_r) begin
      // a release takes a release slot and then a click slot
      if (cur_rel && !phase_r) begin
        phase_r <= 1'b1;
      end else begin
        phase_r <= 1'b0;
        if (last) begin
          active_r <= 1'b0;
        end else begin
          scan_r <= scan_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      press_pend_r <= press_vec;
      rel_pend_r   <= rel_vec;
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> !enq.valid) else $error("ring write outside a scan");

endmodule
`default_nettype wire

// ----- src/bdeq_ring.sv -----
// event ring: one slot kept free, write drops when full, registered read
`default_nettype none
module bdeq_ring #(
  parameter int DEPTH = bdeq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bdeq_pkg::enq_t                  enq,
  input  wire logic                            pop,
  output logic                                 empty,
  output logic [bdeq_pkg::BTN_W-1:0]           rd_button,
  output logic [bdeq_pkg::TYPE_W-1:0]          rd_etype
);

  localparam int PW = $clog2(DEPTH);
  localparam int EW = bdeq_pkg::BTN_W + bdeq_pkg::TYPE_W;

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic          full;
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_q_r;

  assign wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
  assign rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
  assign full       = (wr_ptr_nxt == rd_ptr_r);
  assign empty      = (wr_ptr_r == rd_ptr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (enq.valid && !full) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq.valid && !full) begin
      mem[wr_ptr_r] <= {enq.button, enq.etype};
    end
    if (pop) begin
      rd_q_r <= mem[rd_ptr_r];
    end
  end

  assign rd_button = rd_q_r[EW-1:bdeq_pkg::TYPE_W];
  assign rd_etype  = rd_q_r[bdeq_pkg::TYPE_W-1:0];

  a_full_drops: assert property (@(posedge clk) disable iff (!rst_n)
    enq.valid && full && !pop |=> wr_ptr_r == $past(wr_ptr_r))
    else $error("write accepted into a full ring");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from an empty ring");

  a_no_write_pop_mix: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !enq.valid) else $error("pop during a ring write");

endmodule
`default_nettype wire

// ----- src/button_debouncer_event_queue.sv -----
// top level: nine-lane button debouncer feeding an event ring with pop words
//
// Each input word is either a sample (kind 0: time and raw button levels) or a
// pop (kind 1). A sample closer than tick_period_ms to the last taken sample
// (wrapping 32-bit difference) is dropped. Otherwise all BUTTONS debounce lanes
// update together in the accepting cycle, and the merging stage then walks the
// buttons in order, writing at most one event per cycle into the ring: a press
// gives one event, a release gives a release and then a click. A dropped
// sample leaves the input side free; a taken sample holds the input off until
// the merging stage has walked all the buttons. A pop reads the ring into a
// register, then the output register loads once any stalled earlier result
// has been taken; samples are taken while a result waits. Events beyond
// QUEUE_DEPTH-1 are dropped. The event store has no reset and needs no
// clearing pass. Configuration writes are taken at once.
`default_nettype none
module button_debouncer_event_queue #(
  parameter int BUTTONS     = bdeq_pkg::BUTTONS_DEF,
  parameter int QUEUE_DEPTH = bdeq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input words
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_kind,
  input  wire logic [bdeq_pkg::TIME_W-1:0]       in_now_ms,
  input  wire logic [bdeq_pkg::RAW_W-1:0]        in_raw_levels,
  // result words
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_has_event,
  output logic [bdeq_pkg::BTN_W-1:0]             out_button_index,
  output logic [bdeq_pkg::TYPE_W-1:0]            out_event_type,
  output logic                                   out_click_count,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [bdeq_pkg::CFG_W-1:0]        cfg_wdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_POP} state_t;

  state_t                               state_r, state_nxt;
  logic [bdeq_pkg::TIME_W-1:0]          last_r, last_nxt;
  logic [bdeq_pkg::TICK_W-1:0]          tick_r, tick_nxt;
  logic                                 active_low_r, active_low_nxt;
  logic                                 hit_r, hit_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic                                 has_event_r, has_event_nxt;
  logic [bdeq_pkg::BTN_W-1:0]           button_r, button_nxt;
  logic [bdeq_pkg::TYPE_W-1:0]          etype_r, etype_nxt;

  logic                                 in_acc;
  logic                                 sample_ok;
  logic                                 lane_update;
  logic                                 pop_req;
  logic                                 ring_empty;
  logic [bdeq_pkg::BTN_W-1:0]           rd_button;
  logic [bdeq_pkg::TYPE_W-1:0]          rd_etype;
  logic [bdeq_pkg::TIME_W-1:0]          elapsed;
  logic [BUTTONS-1:0]                   press_vec, rel_vec;
  logic                                 merge_busy;
  logic                                 out_free;
  bdeq_pkg::enq_t                       enq;

  // one word at a time; the output register frees the input side
  assign in_stall    = (state_r != ST_IDLE);
  assign in_acc      = in_valid & ~in_stall;
  assign elapsed     = in_now_ms - last_r;
  assign sample_ok   = (elapsed >= bdeq_pkg::TIME_W'(tick_r));
  assign lane_update = in_acc & ~in_kind & sample_ok;
  assign pop_req     = in_acc & in_kind & ~ring_empty;
  assign out_free    = ~out_valid_r | ~out_stall;

  // debounce lanes, one per button; buttons past the raw field read raw level 0
  for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
    logic                raw_bit;
    bdeq_pkg::lane_req_t req;
    if (b < bdeq_pkg::RAW_W) begin : g_raw
      assign raw_bit = in_raw_levels[b];
    end else begin : g_pad
      assign raw_bit = 1'b0;
    end
    bdeq_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .update (lane_update),
      .level  (raw_bit ^ active_low_r),
      .req    (req)
    );
    assign press_vec[b] = req.press;
    assign rel_vec[b]   = req.rel;
  end

  bdeq_merge #(
    .BUTTONS (BUTTONS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (lane_update),
    .press_vec (press_vec),
    .rel_vec   (rel_vec),
    .busy      (merge_busy),
    .enq       (enq)
  );

  bdeq_ring #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq       (enq),
    .pop       (pop_req),
    .empty     (ring_empty),
    .rd_button (rd_button),
    .rd_etype  (rd_etype)
  );

  always_comb begin
    state_nxt      = state_r;
    last_nxt       = last_r;
    tick_nxt       = tick_r;
    active_low_nxt = active_low_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = out_valid_r;
    has_event_nxt  = has_event_r;
    button_nxt     = button_r;
    etype_nxt      = etype_r;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        bdeq_pkg::CFG_TICK:       tick_nxt       = cfg_wdata;
        bdeq_pkg::CFG_ACTIVE_LOW: active_low_nxt = cfg_wdata[0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind) begin
            hit_nxt   = ~ring_empty;
            state_nxt = ST_POP;
          end else if (sample_ok) begin
            last_nxt  = in_now_ms;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // wait for the merging stage to finish its walk
        if (!merge_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POP: begin
        // ring data is registered now; load once the output slot is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          has_event_nxt = hit_r;
          button_nxt    = hit_r ? rd_button : '0;
          etype_nxt     = hit_r ? rd_etype : bdeq_pkg::EVT_PRESS;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_r       <= '0;
      tick_r       <= bdeq_pkg::TICK_RESET;
      active_low_r <= bdeq_pkg::ACTIVE_LOW_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_r       <= last_nxt;
      tick_r       <= tick_nxt;
      active_low_r <= active_low_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    hit_r       <= hit_nxt;
    has_event_r <= has_event_nxt;
    button_r    <= button_nxt;
    etype_r     <= etype_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_has_event    = has_event_r;
  assign out_button_index = button_r;
  assign out_event_type   = etype_r;
  assign out_click_count  = (etype_r == bdeq_pkg::EVT_CLICK);

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !has_event_r |-> button_r == '0 && etype_r == bdeq_pkg::EVT_PRESS)
    else $error("empty pop carries a non-zero event");

  a_pop_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POP |-> !merge_busy) else $error("pop overlaps an event walk");

endmodule
`default_nettype wire

// ----- tb/bdeq_event_checker.sv -----
// checker for the button debouncer: mirrors the debounce lanes and the event ring, compares pop words
package bdeq_tb_pkg;

  // what an input word asks for
  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_POP    = 1'b1
  } word_kind_t;

endpackage

module bdeq_event_checker
  import bdeq_pkg::*, bdeq_tb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire logic                in_kind,
  input  wire logic [TIME_W-1:0]   in_now_ms,
  input  wire logic [RAW_W-1:0]    in_raw_levels,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire logic                out_has_event,
  input  wire logic [BTN_W-1:0]    out_button_index,
  input  wire logic [TYPE_W-1:0]   out_event_type,
  input  wire logic                out_click_count,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  output int                       errors,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBTN      = BUTTONS_DEF;
  localparam int DEPTH     = QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic              has_event;
    logic [BTN_W-1:0]  button;
    logic [TYPE_W-1:0] etype;
    logic              clicks;
  } pop_word_t;

  logic [TICK_W-1:0] tick_ms;
  logic              low_active;
  logic [TIME_W-1:0] last_taken_ms;
  logic [NBTN-1:0]   settled;
  logic [NBTN-1:0]   seen;
  logic [HOLD_W-1:0] held [NBTN];
  pop_word_t         ring [DEPTH];
  int                head;
  int                tail;
  pop_word_t         expected_pops [$];

  task automatic report(input string msg);
    $display("%0t bdeq check: %s", $time, msg);
    errors++;
  endtask

  // full ring keeps one slot free, the event is simply lost
  function automatic void queue_event(input int btn, input logic [TYPE_W-1:0] et);
    int nxt;
    nxt = (tail + 1) % DEPTH;
    if (nxt == head)
      return;
    ring[tail] = '{has_event: 1'b1, button: BTN_W'(btn), etype: et,
                   clicks: (et == EVT_CLICK)};
    tail = nxt;
  endfunction

  function automatic void debounce_sample(input logic [TIME_W-1:0] now,
                                          input logic [RAW_W-1:0] raw);
    logic [TIME_W-1:0] gap;
    logic              lvl;
    gap = now - last_taken_ms;
    if (gap < TIME_W'(tick_ms))
      return;
    last_taken_ms = now;
    for (int b = 0; b < NBTN; b++) begin
      lvl = raw[b] ^ low_active;
      if (lvl != seen[b]) begin
        held[b] = '0;
        seen[b] = lvl;
      end else if (held[b] < HOLD_SAMPLES) begin
        held[b]++;
        if (held[b] == HOLD_SAMPLES && lvl != settled[b]) begin
          settled[b] = lvl;
          if (lvl) begin
            queue_event(b, EVT_PRESS);
          end else begin
            queue_event(b, EVT_RELEASE);
            queue_event(b, EVT_CLICK);
          end
        end
      end
    end
  endfunction

  function automatic pop_word_t take_oldest_event();
    pop_word_t word;
    word = '0;
    if (head != tail) begin
      word = ring[head];
      head = (head + 1) % DEPTH;
    end
    return word;
  endfunction

  task automatic check_pop_word(input pop_word_t got);
    pop_word_t want;
    if (expected_pops.size() == 0) begin
      report($sformatf("pop word %h with nothing outstanding", got));
      return;
    end
    want = expected_pops.pop_front();
    if (got.has_event != want.has_event)
      report($sformatf("has_event %0d, wanted %0d", got.has_event, want.has_event));
    if (got.button != want.button)
      report($sformatf("button_index %0d, wanted %0d", got.button, want.button));
    if (got.etype != want.etype)
      report($sformatf("event_type %0d, wanted %0d", got.etype, want.etype));
    if (got.clicks != want.clicks)
      report($sformatf("click_count %0d, wanted %0d", got.clicks, want.clicks));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tick_ms       = TICK_RESET;
      low_active    = ACTIVE_LOW_RESET;
      last_taken_ms = '0;
      settled       = '0;
      seen          = '0;
      foreach (held[b])
        held[b] = '0;
      head = 0;
      tail = 0;
      expected_pops.delete();
    end else begin
      if (out_valid && !out_stall)
        check_pop_word(pop_word_t'{out_has_event, out_button_index, out_event_type,
                                   out_click_count});
      if (cfg_we) begin
        if (cfg_index == CFG_TICK)
          tick_ms = cfg_wdata[TICK_W-1:0];
        else
          low_active = cfg_wdata[0];
      end
      if (in_valid && !in_stall) begin
        if (in_kind == KIND_POP)
          expected_pops.push_back(take_oldest_event());
        else
          debounce_sample(in_now_ms, in_raw_levels);
      end
    end
    pending <= expected_pops.size();
  end

endmodule

// ----- tb/button_debouncer_event_queue_tb.sv -----
// testbench top: drives sample and pop words and register writes, then gives the verdict
module button_debouncer_event_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdeq_pkg::*;
  import bdeq_tb_pkg::*;

  // generous ceiling, far above the slowest legal run
  localparam int CYCLE_LIMIT   = 1_000_000;
  // a sample may still be writing events this long after it was taken
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_WORDS   = 235;
  localparam int PHASES        = 8;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic                in_kind          = KIND_SAMPLE;
  logic [TIME_W-1:0]   in_now_ms        = '0;
  logic [RAW_W-1:0]    in_raw_levels    = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic                out_has_event;
  logic [BTN_W-1:0]    out_button_index;
  logic [TYPE_W-1:0]   out_event_type;
  logic                out_click_count;
  logic                cfg_we           = 1'b0;
  logic                cfg_index        = CFG_TICK;
  logic [CFG_W-1:0]    cfg_wdata        = '0;

  int errors;
  int pending;

  // idling odds in percent, changed per phase
  int idle_pct  = 0;
  int stall_pct = 0;

  // register settings per phase, extremes included
  int phase_tick [PHASES] = '{0, 255, 1, 7, 0, 255, 3, 5};
  bit phase_low  [PHASES] = '{0, 1, 1, 0, 1, 0, 1, 0};

  // own view of the sample timing, only to shape the stimulus
  logic [TIME_W-1:0] last_taken_ms = '0;
  int                tick_now      = int'(TICK_RESET);
  logic [RAW_W-1:0]  held_levels   = '1;
  int                words_sent    = 0;
  int                cycles        = 0;

  button_debouncer_event_queue i_dut (.*);

  bdeq_event_checker i_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("button_debouncer_event_queue_tb: errors");
      $finish;
    end
  end

  // receiver back-pressure, never during reset
  always @(posedge clk)
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);

  // one word onto the input channel, held until taken
  task automatic send_word(input word_kind_t kind, input logic [TIME_W-1:0] now,
                           input logic [RAW_W-1:0] raw);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_now_ms     <= now;
    in_raw_levels <= raw;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  // time and levels of a pop are don't-care, so they get noise
  task automatic send_pop();
    words_sent++;
    send_word(KIND_POP, $urandom(), RAW_W'($urandom()));
  endtask

  // samples inside the tick window are dropped by the block and not counted
  task automatic send_sample(input logic [TIME_W-1:0] delta, input logic [RAW_W-1:0] raw);
    logic [TIME_W-1:0] now;
    now = last_taken_ms + delta;
    if (delta >= TIME_W'(tick_now)) begin
      last_taken_ms = now;
      words_sent++;
    end
    send_word(KIND_SAMPLE, now, raw);
  endtask

  // mostly a few ms past the tick, now and then a big jump that wraps the clock
  function automatic logic [TIME_W-1:0] next_gap();
    if ($urandom_range(0, 19) == 0)
      return $urandom() | TIME_W'(32'h100);
    return TIME_W'(tick_now + $urandom_range(0, 20));
  endfunction

  // sender holds off until every pop word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (pending != 0);
  endtask

  task automatic reconfigure(input int tick, input bit low);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TICK;
    cfg_wdata <= CFG_W'(tick);
    @(posedge clk);
    cfg_index <= CFG_ACTIVE_LOW;
    cfg_wdata <= CFG_W'(low);
    @(posedge clk);
    cfg_we    <= 1'b0;
    tick_now = tick;
  endtask

  task automatic run_phase(input int budget, input bit pausing);
    int               stop_at;
    int               pick;
    logic [RAW_W-1:0] target;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // new level pattern held long enough to settle, sometimes bouncing on the way in
        target = ($urandom_range(0, 3) == 0) ? RAW_W'($urandom())
                                             : held_levels ^ RAW_W'($urandom());
        if ($urandom_range(0, 2) == 0)
          send_sample(next_gap(), target ^ RAW_W'($urandom()));
        repeat ($urandom_range(3, 4)) begin
          send_sample(next_gap(), target);
          if ($urandom_range(0, 3) == 0)
            send_pop();
          else if (tick_now > 0 && $urandom_range(0, 9) == 0)
            send_sample(TIME_W'($urandom_range(0, tick_now - 1)), RAW_W'($urandom()));
        end
        held_levels = target;
      end else if (pick < 78) begin
        if (pausing && $urandom_range(0, 4) == 0)
          wait_drained();
        repeat ($urandom_range(1, 12)) send_pop();
      end else if (pick < 83) begin
        // empty the ring and run dry
        repeat (16) send_pop();
      end else if (pick < 94) begin
        send_sample(next_gap(), RAW_W'($urandom()));
      end else if (tick_now > 0) begin
        // too early, must leave no trace
        send_sample(TIME_W'($urandom_range(0, tick_now - 1)), RAW_W'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // pop from an empty ring, then hold off until it is back
    send_pop();
    wait_drained();
    // sample before the first tick after reset is dropped
    send_sample(TIME_W'(3), '0);
    // all nine pressed (active low), settles on the third sample
    repeat (3) send_sample(TIME_W'(5), '0);
    // all released: eighteen events, the ring overflows
    repeat (3) send_sample(TIME_W'(5), '1);
    // fifteen stored events and one empty pop
    repeat (16) send_pop();
    held_levels = '1;

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 65;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 65;
        end
        default: begin
          idle_pct  = 30;
          stall_pct = 30;
        end
      endcase
      reconfigure(phase_tick[p], phase_low[p]);
      run_phase(PHASE_WORDS, (p % 4) == 0);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("button_debouncer_event_queue_tb: clean");
    else
      $display("button_debouncer_event_queue_tb: errors");
    $finish;
  end

endmodule
